### src/srsp_pkg.sv
// ----------------------------------------------------------------------------
// srsp_pkg
// Shared types and codes for the signing-request stream parser: result
// field kinds, status codes, register indexes and the packed result record.
// ----------------------------------------------------------------------------
`default_nettype none

package srsp_pkg;

   // limits on the input and output count and on the script length
   localparam int MAX_ENTRIES_DEF      = 256;
   localparam int MAX_SCRIPT_BYTES_DEF = 1024;

   localparam int TXID_BYTES = 32;

   // configuration register indexes
   localparam logic [1:0] REG_FORMAT_VERSION = 2'd0;
   localparam logic [1:0] REG_MAX_ENTRIES    = 2'd1;
   localparam logic [1:0] REG_MAX_SCRIPT     = 2'd2;

   localparam logic [7:0]  FORMAT_VERSION_RST = 8'h01;
   localparam logic [8:0]  MAX_ENTRIES_RST    = 9'd256;
   localparam logic [10:0] MAX_SCRIPT_RST     = 11'd1024;

   // varint prefixes
   localparam logic [7:0] VARINT_U16 = 8'hfd;
   localparam logic [7:0] VARINT_U32 = 8'hfe;

   // result field kinds
   localparam logic [3:0] KIND_TXVER        = 4'd0;
   localparam logic [3:0] KIND_INCOUNT      = 4'd1;
   localparam logic [3:0] KIND_TXID_BYTE    = 4'd2;
   localparam logic [3:0] KIND_VOUT         = 4'd3;
   localparam logic [3:0] KIND_IN_AMOUNT    = 4'd4;
   localparam logic [3:0] KIND_IN_SCRIPTLEN = 4'd5;
   localparam logic [3:0] KIND_IN_SCRIPT    = 4'd6;
   localparam logic [3:0] KIND_SEQUENCE     = 4'd7;
   localparam logic [3:0] KIND_OUTCOUNT     = 4'd8;
   localparam logic [3:0] KIND_OUT_AMOUNT   = 4'd9;
   localparam logic [3:0] KIND_OUT_SCRIPTLEN = 4'd10;
   localparam logic [3:0] KIND_OUT_SCRIPT   = 4'd11;
   localparam logic [3:0] KIND_LOCKTIME     = 4'd12;
   localparam logic [3:0] KIND_STATUS       = 4'd13;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_VERSION = 3'd1;
   localparam logic [2:0] ST_BAD_COUNT   = 3'd2;
   localparam logic [2:0] ST_SCRIPT_LONG = 3'd3;
   localparam logic [2:0] ST_TRUNCATED   = 3'd4;

   typedef struct packed {
      logic [7:0]  format_version;
      logic [8:0]  max_entry_count;
      logic [10:0] max_script_length;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  field_kind;
      logic [63:0] field_value;
      logic [7:0]  entry_index;
      logic [9:0]  byte_offset;
      logic        done_res;
      logic [2:0]  status;
   } result_type;

endpackage

`default_nettype wire

### src/srsp_parse_core.sv
// ----------------------------------------------------------------------------
// srsp_parse_core
// Parse state registers and the per-byte next-state logic. Each accepted
// request updates the state and yields at most one result in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srsp_parse_core #(
   parameter int MAX_ENTRIES      = srsp_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_SCRIPT_BYTES = srsp_pkg::MAX_SCRIPT_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_fire,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 last_byte,
   input  wire srsp_pkg::cfg_type    cfg,
   output logic                      res_valid,
   output srsp_pkg::result_type      res
);

   typedef enum logic [3:0] {
      PH_FMT     = 4'd0,
      PH_TXVER   = 4'd1,
      PH_INCNT   = 4'd2,
      PH_TXID    = 4'd3,
      PH_VOUT    = 4'd4,
      PH_INAMT   = 4'd5,
      PH_INSLEN  = 4'd6,
      PH_INSCR   = 4'd7,
      PH_SEQ     = 4'd8,
      PH_OUTCNT  = 4'd9,
      PH_OUTAMT  = 4'd10,
      PH_OUTSLEN = 4'd11,
      PH_OUTSCR  = 4'd12,
      PH_LOCK    = 4'd13,
      PH_DONE    = 4'd14
   } phase_type;

   localparam logic [16:0] ENTRY_CAP  = 17'(MAX_ENTRIES);
   localparam logic [16:0] SCRIPT_CAP = 17'(MAX_SCRIPT_BYTES);

   phase_type   phase_ff, phase_in;
   logic [10:0] bcnt_ff, bcnt_in;
   logic [3:0]  vstage_ff, vstage_in;
   logic [63:0] acc_ff, acc_in;
   logic [8:0]  total_ff, total_in;
   logic [8:0]  ecnt_ff, ecnt_in;
   logic [10:0] srem_ff, srem_in;
   logic        failed_ff, failed_in;

   logic [16:0] entry_limit;
   logic [16:0] script_limit;
   logic [63:0] acc_or;
   logic [63:0] vint;
   logic [10:0] bcnt_inc;
   logic [10:0] srem_dec;
   logic [9:0]  ecnt_inc;
   logic        vint_over_entry;
   logic        vint_over_script;
   logic        have;
   logic        finished;
   logic        complete;
   logic        restart;
   logic        nf;
   phase_type   nf_phase;
   logic [2:0]  err;
   logic [3:0]  kind;
   logic [63:0] val;
   logic [7:0]  idx;
   logic [9:0]  off;

   always_comb begin
      entry_limit  = ({8'd0, cfg.max_entry_count} < ENTRY_CAP) ?
                     {8'd0, cfg.max_entry_count} : ENTRY_CAP;
      script_limit = ({6'd0, cfg.max_script_length} < SCRIPT_CAP) ?
                     {6'd0, cfg.max_script_length} : SCRIPT_CAP;
      for (int i = 0; i < 8; i++) begin
         acc_or[i*8 +: 8] = (bcnt_ff[2:0] == 3'(i)) ? (acc_ff[i*8 +: 8] | data_byte)
                                                   : acc_ff[i*8 +: 8];
      end
      bcnt_inc = bcnt_ff + 11'd1;
      srem_dec = (srem_ff != 11'd0) ? (srem_ff - 11'd1) : 11'd0;
      ecnt_inc = {1'b0, ecnt_ff} + 10'd1;
      // single-byte varint or the last byte of a prefixed one
      vint = (vstage_ff == 4'd0) ? {56'd0, data_byte} : acc_or;
      vint_over_entry  = (|vint[63:17]) || (vint[16:0] > entry_limit);
      vint_over_script = (|vint[63:17]) || (vint[16:0] > script_limit);
   end

   always_comb begin
      phase_in  = phase_ff;
      bcnt_in   = bcnt_ff;
      vstage_in = vstage_ff;
      acc_in    = acc_ff;
      total_in  = total_ff;
      ecnt_in   = ecnt_ff;
      srem_in   = srem_ff;
      failed_in = failed_ff;
      have      = 1'b0;
      finished  = 1'b0;
      complete  = 1'b0;
      restart   = 1'b0;
      nf        = 1'b0;
      nf_phase  = phase_ff;
      err       = srsp_pkg::ST_OK;
      kind      = srsp_pkg::KIND_STATUS;
      val       = 64'd0;
      idx       = 8'd0;
      off       = 10'd0;
      res_valid = 1'b0;
      res       = '0;

      if (req_fire) begin
         if (failed_ff || (phase_ff >= PH_DONE)) begin
            // drop bytes until the blob ends
            restart = last_byte;
         end else begin
            kind = 4'(phase_ff) - 4'd1;
            unique case (phase_ff)
               PH_FMT: begin
                  if (data_byte != cfg.format_version) begin
                     err = srsp_pkg::ST_BAD_VERSION;
                  end else begin
                     nf       = 1'b1;
                     nf_phase = PH_TXVER;
                  end
               end
               PH_TXID, PH_INSCR, PH_OUTSCR: begin
                  have    = 1'b1;
                  val     = {56'd0, data_byte};
                  idx     = ecnt_ff[7:0];
                  off     = bcnt_ff[9:0];
                  bcnt_in = bcnt_inc;
                  if (phase_ff == PH_TXID) begin
                     if (bcnt_inc >= 11'(srsp_pkg::TXID_BYTES)) begin
                        nf       = 1'b1;
                        nf_phase = PH_VOUT;
                     end
                  end else begin
                     srem_in = srem_dec;
                     if (srem_dec == 11'd0) begin
                        nf = 1'b1;
                        if (phase_ff == PH_INSCR) begin
                           nf_phase = PH_SEQ;
                        end else begin
                           ecnt_in  = ecnt_inc[8:0];
                           nf_phase = (ecnt_inc >= {1'b0, total_ff}) ? PH_LOCK : PH_OUTAMT;
                        end
                     end
                  end
               end
               PH_INCNT, PH_INSLEN, PH_OUTCNT, PH_OUTSLEN: begin
                  if (vstage_ff == 4'd0) begin
                     if (data_byte < srsp_pkg::VARINT_U16) begin
                        acc_in   = {56'd0, data_byte};
                        complete = 1'b1;
                     end else begin
                        vstage_in = (data_byte == srsp_pkg::VARINT_U16) ? 4'd2 :
                                    (data_byte == srsp_pkg::VARINT_U32) ? 4'd4 : 4'd8;
                        bcnt_in   = 11'd0;
                        acc_in    = 64'd0;
                     end
                  end else begin
                     acc_in    = acc_or;
                     bcnt_in   = bcnt_inc;
                     vstage_in = vstage_ff - 4'd1;
                     complete  = (vstage_ff == 4'd1);
                  end
                  if (complete) begin
                     if (phase_ff == PH_INCNT || phase_ff == PH_OUTCNT) begin
                        if (vint == 64'd0 || vint_over_entry) begin
                           err = srsp_pkg::ST_BAD_COUNT;
                        end else begin
                           have     = 1'b1;
                           val      = vint;
                           total_in = vint[8:0];
                           ecnt_in  = 9'd0;
                           nf       = 1'b1;
                           nf_phase = (phase_ff == PH_INCNT) ? PH_TXID : PH_OUTAMT;
                        end
                     end else begin
                        if (vint_over_script) begin
                           err = srsp_pkg::ST_SCRIPT_LONG;
                        end else begin
                           have    = 1'b1;
                           val     = vint;
                           idx     = ecnt_ff[7:0];
                           srem_in = vint[10:0];
                           nf      = 1'b1;
                           if (phase_ff == PH_INSLEN) begin
                              nf_phase = (vint != 64'd0) ? PH_INSCR : PH_SEQ;
                           end else if (vint != 64'd0) begin
                              nf_phase = PH_OUTSCR;
                           end else begin
                              ecnt_in  = ecnt_inc[8:0];
                              nf_phase = (ecnt_inc >= {1'b0, total_ff}) ? PH_LOCK : PH_OUTAMT;
                           end
                        end
                     end
                  end
               end
               PH_TXVER, PH_VOUT, PH_INAMT, PH_SEQ, PH_OUTAMT, PH_LOCK: begin
                  acc_in  = acc_or;
                  bcnt_in = bcnt_inc;
                  if (bcnt_inc >= ((phase_ff == PH_INAMT || phase_ff == PH_OUTAMT) ?
                                   11'd8 : 11'd4)) begin
                     have = 1'b1;
                     val  = acc_or;
                     idx  = (phase_ff == PH_TXVER || phase_ff == PH_LOCK) ? 8'd0 : ecnt_ff[7:0];
                     nf   = 1'b1;
                     unique case (phase_ff)
                        PH_TXVER:  nf_phase = PH_INCNT;
                        PH_VOUT:   nf_phase = PH_INAMT;
                        PH_INAMT:  nf_phase = PH_INSLEN;
                        PH_SEQ: begin
                           ecnt_in  = ecnt_inc[8:0];
                           nf_phase = (ecnt_inc >= {1'b0, total_ff}) ? PH_OUTCNT : PH_TXID;
                        end
                        PH_OUTAMT: nf_phase = PH_OUTSLEN;
                        default: begin
                           nf_phase = PH_DONE;
                           finished = 1'b1;
                        end
                     endcase
                  end
               end
               default: ;
            endcase

            if (nf) begin
               phase_in  = nf_phase;
               bcnt_in   = 11'd0;
               vstage_in = 4'd0;
               acc_in    = 64'd0;
            end

            if (err != srsp_pkg::ST_OK) begin
               res_valid       = 1'b1;
               res.field_kind  = srsp_pkg::KIND_STATUS;
               res.done_res    = 1'b1;
               res.status      = err;
               restart         = last_byte;
               failed_in       = ~last_byte;
            end else if (finished || last_byte || have) begin
               res_valid       = 1'b1;
               res.field_kind  = have ? kind : srsp_pkg::KIND_STATUS;
               res.field_value = val;
               res.entry_index = idx;
               res.byte_offset = off;
               res.done_res    = finished || last_byte;
               res.status      = (last_byte && !finished) ? srsp_pkg::ST_TRUNCATED
                                                          : srsp_pkg::ST_OK;
               restart         = last_byte;
            end
         end
      end

      if (restart) begin
         phase_in  = PH_FMT;
         bcnt_in   = 11'd0;
         vstage_in = 4'd0;
         acc_in    = 64'd0;
         total_in  = 9'd0;
         ecnt_in   = 9'd0;
         srem_in   = 11'd0;
         failed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FMT;
         bcnt_ff   <= 11'd0;
         vstage_ff <= 4'd0;
         acc_ff    <= 64'd0;
         total_ff  <= 9'd0;
         ecnt_ff   <= 9'd0;
         srem_ff   <= 11'd0;
         failed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         bcnt_ff   <= bcnt_in;
         vstage_ff <= vstage_in;
         acc_ff    <= acc_in;
         total_ff  <= total_in;
         ecnt_ff   <= ecnt_in;
         srem_ff   <= srem_in;
         failed_ff <= failed_in;
      end
   end

   // the entry counter never runs past the count it walks
   a_ecnt_bound: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= total_ff)
      else $error("entry counter beyond entry total");

   // any request flagged last starts the next blob from the format byte
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && last_byte) |=> (phase_ff == PH_FMT && !failed_ff))
      else $error("parser did not restart after last byte");

   // an error or truncation always closes the blob
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status != srsp_pkg::ST_OK) |-> res.done_res)
      else $error("non-ok status without done");

endmodule

`default_nettype wire

### src/srsp_out_buffer.sv
// ----------------------------------------------------------------------------
// srsp_out_buffer
// Result register with a one-entry skid stage, so the parser keeps taking
// requests while a result waits for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module srsp_out_buffer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire srsp_pkg::result_type in_res,
   output logic                      in_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output srsp_pkg::result_type      rsp_res
);

   logic                 out_valid_ff;
   srsp_pkg::result_type out_res_ff;
   logic                 skid_valid_ff;
   srsp_pkg::result_type skid_res_ff;
   logic                 out_fire;

   assign out_fire  = out_valid_ff && rsp_ready;
   assign in_ready  = ~skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // drain the skid stage into the output register
         if (out_fire) begin
            out_res_ff    <= skid_res_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_fire) begin
            out_res_ff   <= in_res;
            out_valid_ff <= 1'b1;
         end else begin
            skid_res_ff   <= in_res;
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a result ahead of the output register");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> (skid_valid_ff && $stable(skid_res_ff)))
      else $error("skid stage lost a result");

   // hold a waiting result until the consumer takes it
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_res_ff)))
      else $error("output register changed while stalled");

endmodule

`default_nettype wire

### src/sign_request_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// sign_request_stream_parser_unit
// Byte-stream parser for a signing-request blob in compact-size transaction
// layout; emits one tagged result per field, txid/script byte, error or cut.
// ----------------------------------------------------------------------------
// Takes one request (one blob byte) per clock cycle for as long as the result
// side keeps up; each accepted request's result is registered before it shows
// on rsp_. The parse state is updated by a single pass of logic per byte,
// and results go through an output register backed by a one-entry skid stage,
// so req_ready drops only when both hold a result the consumer has not taken.
// A byte that completes no field gives no result unless it errs or ends a
// live blob. Configuration writes are taken every cycle (csr_ready is always
// high) and must only be issued while the parser is idle between blobs.
`default_nettype none

module sign_request_stream_parser_unit #(
   parameter int MAX_ENTRIES      = srsp_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_SCRIPT_BYTES = srsp_pkg::MAX_SCRIPT_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_field_kind,
   output logic [63:0]      rsp_field_value,
   output logic [7:0]       rsp_entry_index,
   output logic [9:0]       rsp_byte_offset,
   output logic             rsp_done_res,
   output logic [2:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_data
);

   srsp_pkg::cfg_type    cfg_ff;
   srsp_pkg::result_type core_res;
   srsp_pkg::result_type out_res;
   logic                 core_res_valid;
   logic                 req_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_version    <= srsp_pkg::FORMAT_VERSION_RST;
         cfg_ff.max_entry_count   <= srsp_pkg::MAX_ENTRIES_RST;
         cfg_ff.max_script_length <= srsp_pkg::MAX_SCRIPT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            srsp_pkg::REG_FORMAT_VERSION: cfg_ff.format_version    <= csr_data[7:0];
            srsp_pkg::REG_MAX_ENTRIES:    cfg_ff.max_entry_count   <= csr_data[8:0];
            srsp_pkg::REG_MAX_SCRIPT:     cfg_ff.max_script_length <= csr_data;
            default: ;
         endcase
      end
   end

   srsp_parse_core #(
      .MAX_ENTRIES      (MAX_ENTRIES),
      .MAX_SCRIPT_BYTES (MAX_SCRIPT_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .cfg       (cfg_ff),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   srsp_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_res_valid),
      .in_res    (core_res),
      .in_ready  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (out_res)
   );

   assign rsp_field_kind  = out_res.field_kind;
   assign rsp_field_value = out_res.field_value;
   assign rsp_entry_index = out_res.entry_index;
   assign rsp_byte_offset = out_res.byte_offset;
   assign rsp_done_res    = out_res.done_res;
   assign rsp_status      = out_res.status;

endmodule

`default_nettype wire

### dv/tb_sign_request_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_sign_request_stream_parser_unit
// Self-checking bench for the signing-request stream parser. Builds request
// blobs with random content, mostly well-formed transactions. The rest are
// blobs with a bad version, a bad count, a script that is too long, a cut, or
// trailing bytes. A cycle-level predictor computes each expected result,
// which is compared field by field with what the parser returns. Register
// settings change between phases, and both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_sign_request_stream_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT = 200000;
   localparam logic [7:0] VARINT_U64  = 8'hff;
   localparam logic [1:0] REG_UNUSED  = 2'd3;

   typedef enum logic [3:0] {
      PH_FMT, PH_TXVER, PH_INCNT, PH_TXID, PH_VOUT, PH_INAMT, PH_INSLEN, PH_INSCR,
      PH_SEQ, PH_OUTCNT, PH_OUTAMT, PH_OUTSLEN, PH_OUTSCR, PH_LOCK, PH_DONE
   } parse_phase_type;

   typedef enum {
      FLAW_NONE, FLAW_VERSION, FLAW_COUNT, FLAW_SCRIPT, FLAW_CUT, FLAW_TAIL
   } flaw_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } blob_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_field_kind;
   logic [63:0] rsp_field_value;
   logic [7:0]  rsp_entry_index;
   logic [9:0]  rsp_byte_offset;
   logic        rsp_done_res;
   logic [2:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = srsp_pkg::REG_FORMAT_VERSION;
   logic [10:0] csr_data = 11'd0;

   sign_request_stream_parser_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_kind  (rsp_field_kind),
      .rsp_field_value (rsp_field_value),
      .rsp_entry_index (rsp_entry_index),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_done_res    (rsp_done_res),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   blob_byte_type        pending_bytes[$];
   srsp_pkg::result_type expected_fields[$];
   logic [7:0]           blob_buf[$];
   int                   cut_at;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   bit                   req_taken = 1'b0;
   int                   mismatch_count = 0;
   int                   checked_count = 0;
   int                   error_reports = 0;
   int                   queued_total = 0;
   int                   blob_count = 0;
   int                   cycle_count = 0;

   // predictor copy of the registers and the parse state
   srsp_pkg::cfg_type cfg;
   parse_phase_type   prs_phase;
   int                prs_pos;
   int                prs_stage;
   logic [63:0]       prs_acc;
   int                prs_total;
   int                prs_entry;
   int                prs_left;
   bit                prs_halted;

   function automatic int min_int(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int entry_cap();
      return min_int(int'(cfg.max_entry_count), srsp_pkg::MAX_ENTRIES_DEF);
   endfunction

   function automatic int script_cap();
      return min_int(int'(cfg.max_script_length), srsp_pkg::MAX_SCRIPT_BYTES_DEF);
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      blob_buf.insert(blob_buf.size(), b);
   endfunction

   function automatic void next_field(parse_phase_type p);
      prs_phase = p;
      prs_pos   = 0;
      prs_stage = 0;
      prs_acc   = '0;
   endfunction

   function automatic void clear_parse();
      next_field(PH_FMT);
      prs_total  = 0;
      prs_entry  = 0;
      prs_left   = 0;
      prs_halted = 1'b0;
   endfunction

   // advance to the next input/output, or past the list after the last one
   function automatic void end_entry(parse_phase_type more, parse_phase_type after);
      prs_entry++;
      next_field((prs_entry >= prs_total) ? after : more);
   endfunction

   // advance the parse state by one byte; returns 1 when the byte yields a result
   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     output srsp_pkg::result_type res);
      parse_phase_type ph;
      logic [2:0]      err;
      logic [3:0]      kind;
      logic [63:0]     v;
      bit              have, finished, complete;
      int              n, idx, off;
      ph = prs_phase;
      err = srsp_pkg::ST_OK;
      kind = srsp_pkg::KIND_STATUS;
      v = '0;
      have = 1'b0;
      finished = 1'b0;
      complete = 1'b0;
      idx = 0;
      off = 0;
      res = '0;
      if (prs_halted || ph == PH_DONE) begin
         if (last) clear_parse();
         return 1'b0;
      end
      case (ph)
         PH_FMT: begin
            if (b != cfg.format_version) err = srsp_pkg::ST_BAD_VERSION;
            else next_field(PH_TXVER);
         end
         PH_TXID, PH_INSCR, PH_OUTSCR: begin
            have = 1'b1;
            v = 64'(b);
            idx = prs_entry;
            off = prs_pos;
            prs_pos = (prs_pos + 1) & 'h7ff;
            if (ph == PH_TXID) begin
               if (prs_pos >= srsp_pkg::TXID_BYTES) next_field(PH_VOUT);
            end else begin
               if (prs_left > 0) prs_left--;
               if (prs_left == 0) begin
                  if (ph == PH_INSCR) next_field(PH_SEQ);
                  else end_entry(PH_OUTAMT, PH_LOCK);
               end
            end
         end
         PH_INCNT, PH_INSLEN, PH_OUTCNT, PH_OUTSLEN: begin
            if (prs_stage == 0) begin
               if (b < srsp_pkg::VARINT_U16) begin
                  prs_acc = 64'(b);
                  complete = 1'b1;
               end else begin
                  prs_stage = (b == srsp_pkg::VARINT_U16) ? 2 :
                              (b == srsp_pkg::VARINT_U32) ? 4 : 8;
                  prs_pos = 0;
                  prs_acc = '0;
               end
            end else begin
               prs_acc |= 64'(b) << ((prs_pos & 7) * 8);
               prs_pos++;
               prs_stage--;
               complete = (prs_stage == 0);
            end
            if (complete) begin
               v = prs_acc;
               if (ph == PH_INCNT || ph == PH_OUTCNT) begin
                  if (v == 0 || v > entry_cap()) err = srsp_pkg::ST_BAD_COUNT;
                  else begin
                     have = 1'b1;
                     prs_total = int'(v);
                     prs_entry = 0;
                     next_field((ph == PH_INCNT) ? PH_TXID : PH_OUTAMT);
                  end
               end else if (v > script_cap()) begin
                  err = srsp_pkg::ST_SCRIPT_LONG;
               end else begin
                  have = 1'b1;
                  idx = prs_entry;
                  prs_left = int'(v);
                  if (ph == PH_INSLEN) next_field((v != 0) ? PH_INSCR : PH_SEQ);
                  else if (v != 0) next_field(PH_OUTSCR);
                  else end_entry(PH_OUTAMT, PH_LOCK);
               end
            end
         end
         default: begin
            n = (ph == PH_INAMT || ph == PH_OUTAMT) ? 8 : 4;
            prs_acc |= 64'(b) << ((prs_pos & 7) * 8);
            prs_pos++;
            if (prs_pos >= n) begin
               have = 1'b1;
               v = prs_acc;
               idx = (ph == PH_TXVER || ph == PH_LOCK) ? 0 : prs_entry;
               case (ph)
                  PH_TXVER:  next_field(PH_INCNT);
                  PH_VOUT:   next_field(PH_INAMT);
                  PH_INAMT:  next_field(PH_INSLEN);
                  PH_SEQ:    end_entry(PH_TXID, PH_OUTCNT);
                  PH_OUTAMT: next_field(PH_OUTSLEN);
                  default: begin
                     next_field(PH_DONE);
                     finished = 1'b1;
                  end
               endcase
            end
         end
      endcase
      if (err != srsp_pkg::ST_OK) begin
         res.field_kind = srsp_pkg::KIND_STATUS;
         res.done_res = 1'b1;
         res.status = err;
         if (last) clear_parse();
         else prs_halted = 1'b1;
         return 1'b1;
      end
      if (!have && !last) return 1'b0;
      case (ph)
         PH_TXVER:   kind = srsp_pkg::KIND_TXVER;
         PH_INCNT:   kind = srsp_pkg::KIND_INCOUNT;
         PH_TXID:    kind = srsp_pkg::KIND_TXID_BYTE;
         PH_VOUT:    kind = srsp_pkg::KIND_VOUT;
         PH_INAMT:   kind = srsp_pkg::KIND_IN_AMOUNT;
         PH_INSLEN:  kind = srsp_pkg::KIND_IN_SCRIPTLEN;
         PH_INSCR:   kind = srsp_pkg::KIND_IN_SCRIPT;
         PH_SEQ:     kind = srsp_pkg::KIND_SEQUENCE;
         PH_OUTCNT:  kind = srsp_pkg::KIND_OUTCOUNT;
         PH_OUTAMT:  kind = srsp_pkg::KIND_OUT_AMOUNT;
         PH_OUTSLEN: kind = srsp_pkg::KIND_OUT_SCRIPTLEN;
         PH_OUTSCR:  kind = srsp_pkg::KIND_OUT_SCRIPT;
         default:    kind = srsp_pkg::KIND_LOCKTIME;
      endcase
      if (have) begin
         res.field_kind  = kind;
         res.field_value = v;
         res.entry_index = 8'(idx);
         res.byte_offset = 10'(off);
      end else begin
         res.field_kind = srsp_pkg::KIND_STATUS;
      end
      res.done_res = finished || last;
      res.status   = (last && !finished) ? srsp_pkg::ST_TRUNCATED : srsp_pkg::ST_OK;
      if (last) clear_parse();
      return 1'b1;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // monitor, register shadow and prediction, all on the rising edge
   always @(posedge clock) begin
      srsp_pkg::result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", CYCLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else if (reset) begin
         cfg.format_version    = srsp_pkg::FORMAT_VERSION_RST;
         cfg.max_entry_count   = srsp_pkg::MAX_ENTRIES_RST;
         cfg.max_script_length = srsp_pkg::MAX_SCRIPT_RST;
         clear_parse();
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fields.size() == 0) begin
               $error("unexpected result: kind %0d status %0d", rsp_field_kind, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_fields.pop_front();
               check_field("field_kind", 64'(want.field_kind), 64'(rsp_field_kind));
               check_field("field_value", want.field_value, rsp_field_value);
               check_field("entry_index", 64'(want.entry_index), 64'(rsp_entry_index));
               check_field("byte_offset", 64'(want.byte_offset), 64'(rsp_byte_offset));
               check_field("done_res", 64'(want.done_res), 64'(rsp_done_res));
               check_field("status", 64'(want.status), 64'(rsp_status));
               checked_count++;
               if (want.status != srsp_pkg::ST_OK) error_reports++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               srsp_pkg::REG_FORMAT_VERSION: cfg.format_version    = csr_data[7:0];
               srsp_pkg::REG_MAX_ENTRIES:    cfg.max_entry_count   = csr_data[8:0];
               srsp_pkg::REG_MAX_SCRIPT:     cfg.max_script_length = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (parse_byte(req_data_byte, req_last_byte, want)) begin
               expected_fields.insert(expected_fields.size(), want);
            end
         end
         req_taken <= req_valid && req_ready;
      end
   end

   // request driver and result-side stalls, on the falling edge
   always @(negedge clock) begin
      blob_byte_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = pending_bytes.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_req.data;
            req_last_byte <= next_req.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic put_le(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
   endtask

   // mix canonical and padded compact-size forms
   task automatic put_varint(input logic [63:0] v);
      int form;
      form = $urandom_range(0, 5);
      if (v < 64'hfd && form < 3) begin
         add_byte(v[7:0]);
      end else if (v < 64'h1_0000 && form < 4) begin
         add_byte(srsp_pkg::VARINT_U16);
         put_le(v, 2);
      end else if (v < 64'h1_0000_0000 && form < 5) begin
         add_byte(srsp_pkg::VARINT_U32);
         put_le(v, 4);
      end else begin
         add_byte(VARINT_U64);
         put_le(v, 8);
      end
   endtask

   task automatic put_script(input bit make_bad, input logic [63:0] bad, input int fixed);
      int len;
      if (make_bad) begin
         put_varint(bad);
         if (cut_at < 0) cut_at = blob_buf.size();
      end else begin
         if (fixed >= 0) len = fixed;
         else if ($urandom_range(0, 29) == 0)
            len = $urandom_range(0, min_int(script_cap(), 300));
         else len = $urandom_range(0, min_int(script_cap(), 8));
         put_varint(64'(len));
         repeat (len) add_byte(8'($urandom));
      end
   endtask

   task automatic flush_blob();
      int            n;
      blob_byte_type item;
      n = (cut_at >= 0) ? cut_at : blob_buf.size();
      for (int i = 0; i < n; i++) begin
         item.data = blob_buf[i];
         item.last = (i == n - 1);
         pending_bytes.insert(pending_bytes.size(), item);
      end
      queued_total += n;
      blob_count++;
   endtask

   task automatic queue_blob(input flaw_type flaw, input int script_fixed);
      int          n_in, n_out, bad_slot;
      logic [63:0] bad;
      blob_buf.delete();
      cut_at = -1;
      n_in  = $urandom_range(1, min_int(entry_cap(), 3));
      n_out = $urandom_range(1, min_int(entry_cap(), 3));
      bad_slot = (flaw == FLAW_COUNT) ? $urandom_range(0, 1)
                                      : $urandom_range(0, n_in + n_out - 1);
      bad = 64'(((flaw == FLAW_COUNT) ? entry_cap() : script_cap()) + 1 + $urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
         bad = {$urandom, $urandom};
         bad[40] = 1'b1;
      end else if (flaw == FLAW_COUNT && $urandom_range(0, 2) == 0) begin
         bad = '0;
      end
      if (flaw == FLAW_VERSION) begin
         add_byte(cfg.format_version ^ 8'($urandom_range(1, 255)));
         cut_at = 1;
      end else begin
         add_byte(cfg.format_version);
      end
      put_le({$urandom, $urandom}, 4);
      if (flaw == FLAW_COUNT && bad_slot == 0) begin
         put_varint(bad);
         cut_at = blob_buf.size();
      end else begin
         put_varint(64'(n_in));
      end
      for (int i = 0; i < n_in; i++) begin
         repeat (srsp_pkg::TXID_BYTES) add_byte(8'($urandom));
         put_le({$urandom, $urandom}, 4);
         put_le({$urandom, $urandom}, 8);
         put_script(flaw == FLAW_SCRIPT && bad_slot == i, bad, (i == 0) ? script_fixed : -1);
         put_le({$urandom, $urandom}, 4);
      end
      if (flaw == FLAW_COUNT && bad_slot == 1) begin
         put_varint(bad);
         if (cut_at < 0) cut_at = blob_buf.size();
      end else begin
         put_varint(64'(n_out));
      end
      for (int i = 0; i < n_out; i++) begin
         put_le({$urandom, $urandom}, 8);
         put_script(flaw == FLAW_SCRIPT && bad_slot == n_in + i, bad, -1);
      end
      put_le({$urandom, $urandom}, 4);
      case (flaw)
         FLAW_CUT:  cut_at = $urandom_range(1, blob_buf.size() - 1);
         FLAW_TAIL: repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
         FLAW_NONE: ;
         // end the blob on the error byte or on up to four ignored bytes after it
         default:   cut_at = min_int(cut_at + $urandom_range(0, 4), blob_buf.size());
      endcase
      flush_blob();
   endtask

   task automatic run_random(input int budget);
      int       start, r;
      flaw_type flaw;
      start = queued_total;
      while (queued_total - start < budget) begin
         r = $urandom_range(0, 99);
         flaw = (r < 58) ? FLAW_NONE   : (r < 66) ? FLAW_VERSION :
                (r < 75) ? FLAW_COUNT  : (r < 84) ? FLAW_SCRIPT  :
                (r < 94) ? FLAW_CUT    : FLAW_TAIL;
         queue_blob(flaw, -1);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_config(input logic [7:0] fmt, input logic [8:0] ent,
                               input logic [10:0] scr);
      write_reg(srsp_pkg::REG_FORMAT_VERSION, 11'(fmt));
      write_reg(srsp_pkg::REG_MAX_ENTRIES, 11'(ent));
      write_reg(srsp_pkg::REG_MAX_SCRIPT, scr);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drain, then let the parser settle on bytes that give no result
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_fields.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 37;
      recv_idle_pct = 50;

      // bad version on the final byte
      blob_buf = '{8'h00};
      cut_at = -1;
      flush_blob();
      // zero count in padded form, then one dropped byte
      blob_buf = '{srsp_pkg::FORMAT_VERSION_RST, 8'hff, 8'h00, 8'h7f, 8'h80,
                   srsp_pkg::VARINT_U16, 8'h00, 8'h00, 8'h55};
      flush_blob();
      // blob ends right after the format byte
      blob_buf = '{srsp_pkg::FORMAT_VERSION_RST};
      flush_blob();
      // count of one in eight-byte form, cut on the first txid byte
      blob_buf = '{srsp_pkg::FORMAT_VERSION_RST, 8'h00, 8'h00, 8'h00, 8'h00, VARINT_U64,
                   8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hab};
      flush_blob();
      wait_idle();

      apply_config(8'h00, 9'd1, 11'd0);
      run_random(100);
      wait_idle();

      send_idle_pct = 50;
      recv_idle_pct = 37;
      apply_config(8'hff, 9'd256, 11'd1024);
      queue_blob(FLAW_NONE, 1024);
      run_random(100);
      wait_idle();

      apply_config(8'($urandom), 9'd3, 11'd40);
      queue_blob(FLAW_NONE, 40);
      run_random(100);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(REG_UNUSED, 11'($urandom));
      apply_config(8'($urandom), 9'($urandom_range(1, 256)), 11'($urandom_range(0, 1024)));
      run_random(100);
      wait_idle();

      apply_config(srsp_pkg::FORMAT_VERSION_RST, srsp_pkg::MAX_ENTRIES_RST,
                   srsp_pkg::MAX_SCRIPT_RST);
      run_random(100);
      wait_idle();

      $display("covered %0d requests in %0d blobs over six register settings",
               queued_total, blob_count);
      $display("%0d results checked, %0d of them error or truncation reports",
               checked_count, error_reports);
      if (mismatch_count == 0 && expected_fields.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
src/srsp_pkg.sv
src/srsp_parse_core.sv
src/srsp_out_buffer.sv
src/sign_request_stream_parser_unit.sv
dv/tb_sign_request_stream_parser_unit.sv
